// ===== hdl/bdte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_pkg
// Shared types and constants of the button debouncer with tap and hold events.
// ----------------------------------------------------------------------------
package bdte_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ModeW-1:0] MODE_IDLE     = 2'd0;
  localparam logic [ModeW-1:0] MODE_GAMEPLAY = 2'd1;
  localparam logic [ModeW-1:0] MODE_TUTORIAL = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TIME  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TAP_LIMIT      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_HOLD_TIME = 2'd2;

  localparam logic [CfgW-1:0] DEBOUNCE_TIME_RST  = 16'd30;
  localparam logic [CfgW-1:0] TAP_LIMIT_RST      = 16'd500;
  localparam logic [CfgW-1:0] LONG_HOLD_TIME_RST = 16'd5000;

  typedef struct packed {
    logic             raw_pressed;
    logic [TimeW-1:0] now_ms;
    logic [ModeW-1:0] run_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0] down_events;
    logic       up_event;
    logic       push_event;
    logic       long_hold_event;
    logic       pressed_level;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] tap_limit;
    logic [CfgW-1:0] long_hold_time;
  } cfg_t;

  typedef struct packed {
    logic             stable_level;
    logic             last_raw;
    logic [TimeW-1:0] raw_change_time;
    logic [TimeW-1:0] press_start_time;
    logic             held;
    logic             long_hold_armed;
    logic             early_down_sent;
  } btn_state_t;

endpackage

// ===== hdl/button_debounce_tap_hold_events.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_tap_hold_events
// Button debouncer that reports down, up, tap and long-hold events per sample.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
// out      output     out_valid_o / out_stall_i  out_data_o (out_item_t)
// cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// A sample is registered in the input register on acceptance, and its result
// is then registered in the output register. One transaction can be accepted
// every cycle while the output is not stalled. The button state updates when
// a sample moves into the output register. A stall on the output holds both
// stages. Reset restores the register defaults and clears the button state.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold_events
  import bdte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q;
  out_item_t  out_d;
  logic       out_vld_q;
  btn_state_t state_q;
  btn_state_t state_d;
  logic       advance;

  bdte_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdte_step u_step (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/bdte_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_cfg_regs
// Timing configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bdte_cfg_regs
  import bdte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time  <= DEBOUNCE_TIME_RST;
      cfg_q.tap_limit      <= TAP_LIMIT_RST;
      cfg_q.long_hold_time <= LONG_HOLD_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_TIME:  cfg_q.debounce_time  <= cfg_wdata_i;
        REG_TAP_LIMIT:      cfg_q.tap_limit      <= cfg_wdata_i;
        REG_LONG_HOLD_TIME: cfg_q.long_hold_time <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bdte_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_step
// Next-state and event logic for one button sample.
// ----------------------------------------------------------------------------
module bdte_step
  import bdte_pkg::*;
(
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  input  btn_state_t state_i,
  output btn_state_t state_o,
  output out_item_t  result_o
);

  logic             quiet;
  logic             accept;
  logic             down_deb;
  logic             down_raw;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] press_len;
  logic [TimeW-1:0] hold_len;
  btn_state_t       s1;
  btn_state_t       s2;

  always_comb begin
    quiet    = (item_i.run_mode == MODE_TUTORIAL);
    s1       = state_i;
    down_deb = 1'b0;
    down_raw = 1'b0;
    result_o = '0;

    if (item_i.raw_pressed != state_i.last_raw) begin
      s1.last_raw        = item_i.raw_pressed;
      s1.raw_change_time = item_i.now_ms;
    end

    since_change = item_i.now_ms - s1.raw_change_time;
    press_len    = item_i.now_ms - state_i.press_start_time;
    accept       = (s1.stable_level != s1.last_raw) &&
                   (since_change >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_time});

    if (accept) begin
      s1.stable_level    = s1.last_raw;
      s1.long_hold_armed = 1'b0;
      if (s1.last_raw) begin
        s1.held             = 1'b1;
        s1.press_start_time = item_i.now_ms;
        down_deb            = !state_i.early_down_sent && !quiet;
      end else begin
        s1.held             = 1'b0;
        result_o.up_event   = !quiet;
        result_o.push_event = !quiet &&
          (press_len < {{(TimeW-CfgW){1'b0}}, cfg_i.tap_limit});
        s1.early_down_sent  = 1'b0;
      end
    end

    s2 = s1;
    if (s1.last_raw && !s1.early_down_sent) begin
      down_raw           = !quiet;
      s2.early_down_sent = 1'b1;
    end

    hold_len = item_i.now_ms - s2.press_start_time;
    if (s2.held && (item_i.run_mode == MODE_IDLE) && !s2.long_hold_armed &&
        (hold_len >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_hold_time})) begin
      s2.long_hold_armed       = 1'b1;
      result_o.long_hold_event = 1'b1;
    end

    result_o.down_events   = {1'b0, down_deb} + {1'b0, down_raw};
    result_o.pressed_level = s2.stable_level;
    state_o                = s2;
  end

endmodule

// ===== sim/bdte_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_event_checker
// Scoreboard for the button debouncer. It watches the configuration port and
// both channels, keeps its own copy of the button state and registers, works
// out the event flags of every accepted sample, and compares each accepted
// result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bdte_event_checker
  import bdte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o
);

  btn_state_t  btn;
  cfg_t        regs;
  out_item_t   pending_events[$];
  out_item_t   oldest;
  int unsigned mismatch_count;
  int unsigned pending_count;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = pending_count;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic out_item_t track_sample(in_item_t s);
    out_item_t        ev;
    logic             quiet;
    logic [1:0]       downs;
    logic [TimeW-1:0] since;
    ev    = '0;
    quiet = (s.run_mode == MODE_TUTORIAL);
    downs = 2'd0;
    if (s.raw_pressed != btn.last_raw) begin
      btn.last_raw        = s.raw_pressed;
      btn.raw_change_time = s.now_ms;
    end
    since = s.now_ms - btn.raw_change_time;
    if (btn.stable_level != btn.last_raw && since >= TimeW'(regs.debounce_time)) begin
      btn.stable_level = btn.last_raw;
      if (btn.stable_level) begin
        btn.held             = 1'b1;
        btn.press_start_time = s.now_ms;
        btn.long_hold_armed  = 1'b0;
        if (!btn.early_down_sent && !quiet) begin
          downs = downs + 2'd1;
        end
      end else begin
        since               = s.now_ms - btn.press_start_time;
        btn.held            = 1'b0;
        btn.long_hold_armed = 1'b0;
        if (!quiet) begin
          ev.up_event   = 1'b1;
          ev.push_event = (since < TimeW'(regs.tap_limit));
        end
        btn.early_down_sent = 1'b0;
      end
    end
    if (btn.last_raw && !btn.early_down_sent) begin
      if (!quiet) begin
        downs = downs + 2'd1;
      end
      btn.early_down_sent = 1'b1;
    end
    since = s.now_ms - btn.press_start_time;
    if (btn.held && s.run_mode == MODE_IDLE && !btn.long_hold_armed &&
        since >= TimeW'(regs.long_hold_time)) begin
      btn.long_hold_armed = 1'b1;
      ev.long_hold_event  = 1'b1;
    end
    ev.down_events   = downs;
    ev.pressed_level = btn.stable_level;
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn  = '0;
      regs = {DEBOUNCE_TIME_RST, TAP_LIMIT_RST, LONG_HOLD_TIME_RST};
      pending_events.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          oldest = pending_events.pop_front();
          check_field("down_events", 32'(out_data_i.down_events),
                      32'(oldest.down_events));
          check_field("up_event", 32'(out_data_i.up_event), 32'(oldest.up_event));
          check_field("push_event", 32'(out_data_i.push_event),
                      32'(oldest.push_event));
          check_field("long_hold_event", 32'(out_data_i.long_hold_event),
                      32'(oldest.long_hold_event));
          check_field("pressed_level", 32'(out_data_i.pressed_level),
                      32'(oldest.pressed_level));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE_TIME:  regs.debounce_time  = cfg_wdata_i;
          REG_TAP_LIMIT:      regs.tap_limit      = cfg_wdata_i;
          REG_LONG_HOLD_TIME: regs.long_hold_time = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        pending_events.push_back(track_sample(in_data_i));
      end
      pending_count = pending_events.size();
    end
  end

endmodule

// ===== sim/button_debounce_tap_hold_events_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_tap_hold_events_tb
// Drives button samples through the debouncer under several register
// settings: a directed sequence at the reset defaults, then press and release
// sequences with bounce, taps, long holds and noise, with random idling on
// both channels. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold_events_tb;
  import bdte_pkg::*;

  localparam int unsigned       CycleLimit  = 200000;
  localparam logic [ModeW-1:0]  MODE_UNUSED = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = REG_DEBOUNCE_TIME;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  int unsigned        mismatches;
  int unsigned        outstanding;
  int unsigned        cycles = 0;
  int unsigned        samples_sent = 0;
  logic               calm = 1'b0;
  logic [TimeW-1:0]   t_ms = '0;
  int unsigned        db_ms;
  int unsigned        tap_ms;
  int unsigned        hold_ms;

  button_debounce_tap_hold_events dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bdte_event_checker event_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(99) < 11);
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_timing(int unsigned db, int unsigned tap, int unsigned hold);
    db_ms   = db;
    tap_ms  = tap;
    hold_ms = hold;
    write_reg(REG_DEBOUNCE_TIME, CfgW'(db));
    write_reg(REG_TAP_LIMIT, CfgW'(tap));
    write_reg(REG_LONG_HOLD_TIME, CfgW'(hold));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic send_at(logic raw, logic [TimeW-1:0] now, logic [ModeW-1:0] mode);
    in_item_t    s;
    int unsigned gap;
    s.raw_pressed = raw;
    s.now_ms      = now;
    s.run_mode    = mode;
    t_ms          = now;
    gap           = 0;
    if (!calm && $urandom_range(99) < 11) begin
      gap = 1;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent = samples_sent + 1;
  endtask

  task automatic tick_send(logic raw, int unsigned step, logic [ModeW-1:0] mode);
    logic [ModeW-1:0] m;
    m = mode;
    if ($urandom_range(9) == 0) begin
      m = ModeW'($urandom_range(3));
    end
    send_at(raw, t_ms + step, m);
  endtask

  task automatic bounce_to(logic level, logic [ModeW-1:0] mode);
    int unsigned n;
    n = $urandom_range(3);
    repeat (n) begin
      tick_send(level, $urandom_range(db_ms / 2), mode);
      tick_send(!level, $urandom_range(db_ms / 2), mode);
    end
    tick_send(level, $urandom_range(db_ms / 2), mode);
    tick_send(level, (db_ms == 0) ? $urandom_range(1) : db_ms - 1 + $urandom_range(2),
              mode);
    tick_send(level, $urandom_range(1, db_ms / 2 + 1), mode);
  endtask

  task automatic press_cycle();
    logic [ModeW-1:0] mode;
    int unsigned      r;
    int unsigned      dur;
    int unsigned      parts;
    r    = $urandom_range(99);
    mode = (r < 45) ? MODE_IDLE : (r < 75) ? MODE_GAMEPLAY :
           (r < 92) ? MODE_TUTORIAL : MODE_UNUSED;
    bounce_to(1'b1, mode);
    r   = $urandom_range(99);
    dur = (r < 35) ? $urandom_range(tap_ms) :
          (r < 70) ? hold_ms + $urandom_range(hold_ms / 4 + 2) :
                     $urandom_range(2 * hold_ms + 10);
    parts = $urandom_range(1, 4);
    repeat (parts) tick_send(1'b1, dur / parts, mode);
    bounce_to(1'b0, mode);
  endtask

  task automatic noise_sample();
    tick_send(1'($urandom_range(1)),
              ($urandom_range(99) < 25) ? $urandom() : $urandom_range(db_ms + 2),
              ModeW'($urandom_range(3)));
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned stop_at;
    stop_at = samples_sent + quota;
    while (samples_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        press_cycle();
      end else begin
        repeat ($urandom_range(1, 4)) noise_sample();
      end
    end
  endtask

  initial begin
    db_ms   = 32'(DEBOUNCE_TIME_RST);
    tap_ms  = 32'(TAP_LIMIT_RST);
    hold_ms = 32'(LONG_HOLD_TIME_RST);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bounce on press, long hold in idle, then a slow release.
    send_at(1'b0, 32'd0, MODE_IDLE);
    send_at(1'b1, 32'd10, MODE_IDLE);
    send_at(1'b0, 32'd15, MODE_IDLE);
    send_at(1'b1, 32'd20, MODE_IDLE);
    send_at(1'b1, 32'd60, MODE_IDLE);
    send_at(1'b1, 32'd5060, MODE_IDLE);
    send_at(1'b1, 32'd6000, MODE_IDLE);
    send_at(1'b0, 32'd6010, MODE_IDLE);
    send_at(1'b0, 32'd6040, MODE_IDLE);
    // A short tap in gameplay.
    send_at(1'b1, 32'd7000, MODE_GAMEPLAY);
    send_at(1'b1, 32'd7030, MODE_GAMEPLAY);
    send_at(1'b0, 32'd7100, MODE_GAMEPLAY);
    send_at(1'b0, 32'd7130, MODE_GAMEPLAY);
    // Tutorial mode stays quiet.
    send_at(1'b1, 32'd8000, MODE_TUTORIAL);
    send_at(1'b1, 32'd8040, MODE_TUTORIAL);
    send_at(1'b0, 32'd8100, MODE_TUTORIAL);
    send_at(1'b0, 32'd8140, MODE_TUTORIAL);
    // The unused mode never raises a long hold.
    send_at(1'b1, 32'd9000, MODE_UNUSED);
    send_at(1'b1, 32'd9030, MODE_UNUSED);
    send_at(1'b1, 32'd15000, MODE_UNUSED);
    send_at(1'b0, 32'd15010, MODE_UNUSED);
    // Timestamps that wrap around.
    send_at(1'b1, 32'hFFFF_FFF0, MODE_IDLE);
    send_at(1'b1, 32'h0000_000E, MODE_IDLE);
    send_at(1'b0, 32'h0000_0020, MODE_IDLE);
    send_at(1'b0, 32'hFFFF_FFFF, MODE_IDLE);
    wait_drained();

    // No debounce: a press is accepted at once and counts two downs.
    set_timing(0, 65535, 0);
    send_at(1'b1, t_ms + 5, MODE_IDLE);
    send_at(1'b0, t_ms + 1, MODE_IDLE);
    random_phase(150);
    wait_drained();

    set_timing(65535, 0, 65535);
    t_ms = 32'hFFFF_0000;
    random_phase(150);
    wait_drained();

    set_timing($urandom_range(1, 50), $urandom_range(10, 600), $urandom_range(50, 2000));
    calm = 1'b1;
    random_phase(200);
    calm = 1'b0;
    wait_drained();

    repeat (2) begin
      set_timing($urandom_range(60), $urandom_range(1000), $urandom_range(3000));
      t_ms = $urandom();
      random_phase(175);
      wait_drained();
    end

    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bdte_pkg.sv
hdl/bdte_cfg_regs.sv
hdl/bdte_step.sv
hdl/button_debounce_tap_hold_events.sv
sim/bdte_event_checker.sv
sim/button_debounce_tap_hold_events_tb.sv
